// ===== rtl/core/irpdt_pkg.sv =====
package irpdt_pkg;

  localparam int MAX_BYTES_DEF = 5;
  localparam int PAYLOAD_W     = 40;
  localparam int COUNT_W       = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 12;
  localparam int S_TDATA_W     = 48;
  localparam int M_TDATA_W     = 8;

  // result bit positions in m_tdata
  localparam int RES_LEVEL_BIT = 0;
  localparam int RES_BUSY_BIT  = 1;
  localparam int RES_REJ_BIT   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_UNIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_SPACE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CARRIER      = 3'd6;

  // item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [2:0] {
    SEG_IDLE,
    SEG_LEAD_MARK,
    SEG_LEAD_SPACE,
    SEG_BIT_MARK,
    SEG_BIT_SPACE,
    SEG_STOP_MARK
  } seg_t;

  typedef struct packed {
    logic [11:0] leader_mark_ticks;
    logic [9:0]  bit_mark_ticks;
    logic [9:0]  space_unit_ticks;
    logic [3:0]  leader_space_units;
    logic [3:0]  one_space_units;
    logic [3:0]  zero_space_units;
    logic [3:0]  carrier_period;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    leader_mark_ticks:  12'd1038,
    bit_mark_ticks:     10'd66,
    space_unit_ticks:   10'd64,
    leader_space_units: 4'd8,
    one_space_units:    4'd3,
    zero_space_units:   4'd1,
    carrier_period:     4'd3
  };

  // classified item as it sits in the queue
  typedef struct packed {
    logic                 is_start;
    logic [COUNT_W-1:0]   nbytes;
    logic [PAYLOAD_W-1:0] payload;
  } cmd_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic frame_done;
    logic start_rejected;
  } res_t;

endpackage

// ===== rtl/core/ir_pulse_distance_transmitter.sv =====
// pulse-distance infrared transmitter
// s_t* carries items: tuser = kind (0 tick, 1 start), tdata = byte_count and payload.
// a start loads up to MAX_BYTES payload bytes (count saturates) and begins a frame:
// leader mark, leader space, each byte then its complement lsb first, stop mark.
// every tick item advances the frame by one tick; every item gives one result item
// on m_t*: tdata = ir_level, busy_res, start_rejected; tlast = frame_done.
// a start that arrives while a frame is running is dropped and flagged.
// cfg_* writes the timing registers by index; cfg_ready is always high and writes
// should be done only while no frame is running and no item is in flight.
// each item is written into the queue, then taken by the frame engine, which registers its result.
// throughput: one item per clock while m_tready does not hold the result.
// a two-entry queue between input classification and the frame engine, plus the
// result register, lets either side stall; s_tready drops only with the queue full.
// while m_tready is low the result holds, the engine stops and the queue fills.
// reset (rst, synchronous) restores the register defaults, empties the queue,
// idles the frame engine and leaves the pin level high.
module ir_pulse_distance_transmitter #(
  parameter int MAX_BYTES = irpdt_pkg::MAX_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [irpdt_pkg::S_TDATA_W-1:0]  s_tdata,  // byte_count[2:0], payload[42:3]
  input  logic                             s_tuser,  // kind
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [irpdt_pkg::M_TDATA_W-1:0]  m_tdata,  // ir_level, busy_res, start_rejected
  output logic                             m_tlast,  // frame_done
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [irpdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpdt_pkg::CFG_DATA_W-1:0] cfg_data
);

  irpdt_pkg::cfg_t cfg;
  irpdt_pkg::cmd_t in_cmd;
  irpdt_pkg::cmd_t q_cmd;
  irpdt_pkg::res_t res;
  logic       q_valid;
  logic       q_ready;
  logic [2:0] raw_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= irpdt_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        irpdt_pkg::CFG_LEADER_MARK:  cfg.leader_mark_ticks  <= cfg_data;
        irpdt_pkg::CFG_BIT_MARK:     cfg.bit_mark_ticks     <= cfg_data[9:0];
        irpdt_pkg::CFG_SPACE_UNIT:   cfg.space_unit_ticks   <= cfg_data[9:0];
        irpdt_pkg::CFG_LEADER_SPACE: cfg.leader_space_units <= cfg_data[3:0];
        irpdt_pkg::CFG_ONE_SPACE:    cfg.one_space_units    <= cfg_data[3:0];
        irpdt_pkg::CFG_ZERO_SPACE:   cfg.zero_space_units   <= cfg_data[3:0];
        irpdt_pkg::CFG_CARRIER:      cfg.carrier_period     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // classify the item and clamp the byte count
  assign raw_count       = s_tdata[2:0];
  assign in_cmd.is_start = (s_tuser == irpdt_pkg::KIND_START);
  assign in_cmd.nbytes   = ({1'b0, raw_count} > 4'(MAX_BYTES)) ? 3'(MAX_BYTES) : raw_count;
  assign in_cmd.payload  = s_tdata[3 +: irpdt_pkg::PAYLOAD_W];

  irpdt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (in_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  irpdt_engine #(
    .MAX_BYTES (MAX_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  always_comb begin
    m_tdata = '0;
    m_tdata[irpdt_pkg::RES_LEVEL_BIT] = res.ir_level;
    m_tdata[irpdt_pkg::RES_BUSY_BIT]  = res.busy_res;
    m_tdata[irpdt_pkg::RES_REJ_BIT]   = res.start_rejected;
  end
  assign m_tlast = res.frame_done;

  // a queued item reaches the result register when that register is empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    q_valid && !m_tvalid |=> m_tvalid)
    else $error("queued item not moved to the result register");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a frame end never coincides with a rejected start and always reports busy
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[irpdt_pkg::RES_BUSY_BIT] &&
                            !m_tdata[irpdt_pkg::RES_REJ_BIT])
    else $error("frame end flagged outside a frame");

endmodule

// ===== rtl/core/irpdt_queue.sv =====
module irpdt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  irpdt_pkg::cmd_t in_cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output irpdt_pkg::cmd_t out_cmd
);

  irpdt_pkg::cmd_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/core/irpdt_engine.sv =====
module irpdt_engine #(
  parameter int MAX_BYTES = irpdt_pkg::MAX_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  irpdt_pkg::cfg_t cfg,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  irpdt_pkg::cmd_t cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output irpdt_pkg::res_t res
);

  localparam int FRAME_W = 8 * MAX_BYTES;

  irpdt_pkg::seg_t segment, segment_next;
  logic [11:0]          tick_counter, tick_counter_next;
  logic [3:0]           unit_counter, unit_counter_next;
  logic [3:0]           carrier_phase, carrier_phase_next;
  logic [6:0]           bit_position, bit_position_next;
  logic [FRAME_W-1:0]   frame_bytes, frame_bytes_next;
  logic [2:0]           bytes_in_frame, bytes_in_frame_next;
  logic                 held_level;

  irpdt_pkg::res_t res_now;
  logic        take;
  logic [12:0] tick_inc;
  logic [11:0] mark_len;
  logic        mark_end;
  logic        unit_tick_end;
  logic [3:0]  space_units;
  logic [4:0]  unit_inc;
  logic        space_end;
  logic [4:0]  phase_inc;
  logic [3:0]  phase_step;
  logic [6:0]  pos_inc;
  logic [6:0]  frame_bits;
  logic [FRAME_W-1:0] frame_shift;
  logic [7:0]  cur_byte;
  logic        cur_bit;
  logic        in_mark;

  assign cmd_ready = !res_valid || res_ready;
  assign take      = cmd_valid && cmd_ready;

  assign tick_inc      = {1'b0, tick_counter} + 13'd1;
  assign mark_len      = (segment == irpdt_pkg::SEG_LEAD_MARK) ? cfg.leader_mark_ticks
                                                               : {2'b00, cfg.bit_mark_ticks};
  assign mark_end      = tick_inc >= {1'b0, mark_len};
  assign unit_tick_end = tick_inc >= {3'b000, cfg.space_unit_ticks};

  // pick the bit under transmission: byte, then complement half, then bit
  assign frame_shift = frame_bytes >> {bit_position[6:4], 3'b000};
  assign cur_byte    = frame_shift[7:0];
  assign cur_bit     = cur_byte[bit_position[2:0]] ^ bit_position[3];

  assign space_units = (segment == irpdt_pkg::SEG_LEAD_SPACE) ? cfg.leader_space_units :
                       cur_bit ? cfg.one_space_units : cfg.zero_space_units;
  assign unit_inc    = {1'b0, unit_counter} + 5'd1;
  assign space_end   = unit_tick_end && (unit_inc >= {1'b0, space_units});

  assign phase_inc  = {1'b0, carrier_phase} + 5'd1;
  assign phase_step = (phase_inc >= {1'b0, cfg.carrier_period}) ? 4'd0 : phase_inc[3:0];

  assign pos_inc    = bit_position + 7'd1;
  assign frame_bits = {bytes_in_frame, 4'b0000};

  assign in_mark = (segment == irpdt_pkg::SEG_LEAD_MARK) ||
                   (segment == irpdt_pkg::SEG_BIT_MARK) ||
                   (segment == irpdt_pkg::SEG_STOP_MARK);

  // next state
  always_comb begin
    segment_next        = segment;
    tick_counter_next   = tick_counter;
    unit_counter_next   = unit_counter;
    carrier_phase_next  = carrier_phase;
    bit_position_next   = bit_position;
    frame_bytes_next    = frame_bytes;
    bytes_in_frame_next = bytes_in_frame;
    if (cmd.is_start) begin
      if (segment == irpdt_pkg::SEG_IDLE) begin
        bytes_in_frame_next = cmd.nbytes;
        frame_bytes_next    = FRAME_W'(cmd.payload);
        bit_position_next   = 7'd0;
        tick_counter_next   = 12'd0;
        unit_counter_next   = 4'd0;
        segment_next        = irpdt_pkg::SEG_LEAD_MARK;
      end
    end else begin
      if (in_mark) begin
        carrier_phase_next = phase_step;
        tick_counter_next  = mark_end ? 12'd0 : tick_inc[11:0];
      end else if (segment != irpdt_pkg::SEG_IDLE) begin
        if (unit_tick_end) begin
          tick_counter_next = 12'd0;
          unit_counter_next = space_end ? 4'd0 : unit_inc[3:0];
        end else begin
          tick_counter_next = tick_inc[11:0];
        end
      end
      unique case (segment)
        irpdt_pkg::SEG_LEAD_MARK: begin
          if (mark_end) begin
            segment_next = irpdt_pkg::SEG_LEAD_SPACE;
          end
        end
        irpdt_pkg::SEG_LEAD_SPACE: begin
          if (space_end) begin
            bit_position_next = 7'd0;
            segment_next = (bytes_in_frame == 3'd0) ? irpdt_pkg::SEG_STOP_MARK
                                                    : irpdt_pkg::SEG_BIT_MARK;
          end
        end
        irpdt_pkg::SEG_BIT_MARK: begin
          if (mark_end) begin
            segment_next = irpdt_pkg::SEG_BIT_SPACE;
          end
        end
        irpdt_pkg::SEG_BIT_SPACE: begin
          if (space_end) begin
            bit_position_next = pos_inc;
            segment_next = (pos_inc >= frame_bits) ? irpdt_pkg::SEG_STOP_MARK
                                                   : irpdt_pkg::SEG_BIT_MARK;
          end
        end
        irpdt_pkg::SEG_STOP_MARK: begin
          if (mark_end) begin
            segment_next = irpdt_pkg::SEG_IDLE;
          end
        end
        default: begin
          segment_next = irpdt_pkg::SEG_IDLE;
        end
      endcase
    end
  end

  // result of the item being taken
  always_comb begin
    res_now = '{ir_level: 1'b1, busy_res: 1'b0, frame_done: 1'b0, start_rejected: 1'b0};
    if (cmd.is_start) begin
      res_now.ir_level       = held_level;
      res_now.busy_res       = 1'b1;
      res_now.start_rejected = (segment != irpdt_pkg::SEG_IDLE);
    end else if (segment != irpdt_pkg::SEG_IDLE) begin
      res_now.busy_res = 1'b1;
      if (in_mark) begin
        res_now.ir_level = (carrier_phase != 4'd0);
      end
      res_now.frame_done = (segment == irpdt_pkg::SEG_STOP_MARK) && mark_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment        <= irpdt_pkg::SEG_IDLE;
      tick_counter   <= 12'd0;
      unit_counter   <= 4'd0;
      carrier_phase  <= 4'd0;
      bit_position   <= 7'd0;
      frame_bytes    <= '0;
      bytes_in_frame <= 3'd0;
      held_level     <= 1'b1;
      res_valid      <= 1'b0;
    end else begin
      if (take) begin
        segment        <= segment_next;
        tick_counter   <= tick_counter_next;
        unit_counter   <= unit_counter_next;
        carrier_phase  <= carrier_phase_next;
        bit_position   <= bit_position_next;
        frame_bytes    <= frame_bytes_next;
        bytes_in_frame <= bytes_in_frame_next;
        if (!cmd.is_start) begin
          held_level <= res_now.ir_level;
        end
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_now;
    end
  end

endmodule
